>>> rtl/p3rsp_pkg.sv
// ----------------------------------------------------------------------------
// p3rsp_pkg
// Types and constants shared by the POP3 server response stream parser.
// ----------------------------------------------------------------------------
package p3rsp_pkg;

  // Parser state, one per position within a server line
  typedef enum logic [3:0] {
    ST_RESP = 4'd0,   // line start, awaiting a response
    ST_O    = 4'd1,   // saw '+', expect 'O'
    ST_K    = 4'd2,   // saw "+O", expect 'K'
    ST_E    = 4'd3,   // saw '-', expect 'E'
    ST_R1   = 4'd4,   // saw "-E", expect 'R'
    ST_R2   = 4'd5,   // saw "-ER", expect 'R'
    ST_OKSP = 4'd6,   // after "+OK", skipping blanks
    ST_EOL  = 4'd7,   // skip to end of line
    ST_LOOK = 4'd8,   // greeting line, looking for '<'
    ST_CHAL = 4'd9,   // inside the APOP challenge
    ST_BSOL = 4'd10,  // body, start of line
    ST_BMID = 4'd11,  // body, middle of line
    ST_DOT  = 4'd12,  // body line that opened with '.'
    ST_CR   = 4'd13   // ".\r" seen
  } state_t;

  // Event codes of a result
  localparam logic [2:0] EV_NONE = 3'd0;
  localparam logic [2:0] EV_OK   = 3'd1;
  localparam logic [2:0] EV_ERR  = 3'd2;
  localparam logic [2:0] EV_BODY = 3'd3;
  localparam logic [2:0] EV_EOM  = 3'd4;
  localparam logic [2:0] EV_CHAL = 3'd5;

  // Request types
  localparam logic REQ_SERVER_BYTE = 1'b0;
  localparam logic REQ_CLIENT_CMD  = 1'b1;

  // Characters of interest
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_O_UC  = 8'h4F;
  localparam logic [7:0] CH_O_LC  = 8'h6F;
  localparam logic [7:0] CH_K_UC  = 8'h4B;
  localparam logic [7:0] CH_K_LC  = 8'h6B;
  localparam logic [7:0] CH_E_UC  = 8'h45;
  localparam logic [7:0] CH_E_LC  = 8'h65;
  localparam logic [7:0] CH_R_UC  = 8'h52;
  localparam logic [7:0] CH_R_LC  = 8'h72;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;

  // One result item
  typedef struct packed {
    logic [2:0] event_code;
    logic [7:0] out_byte;
    logic       challenge_last;
  } result_t;

endpackage

>>> rtl/p3rsp_req_if.sv
// ----------------------------------------------------------------------------
// p3rsp_req_if
// Request channel: one server byte or one client command event.
// ----------------------------------------------------------------------------
interface p3rsp_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] data_byte;

  modport source (output valid, output req_type, output data_byte, input ready);
  modport sink   (input valid, input req_type, input data_byte, output ready);
endinterface

>>> rtl/p3rsp_rsp_if.sv
// ----------------------------------------------------------------------------
// p3rsp_rsp_if
// Result channel: one parser event per request.
// ----------------------------------------------------------------------------
interface p3rsp_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_code;
  logic [7:0] out_byte;
  logic       challenge_last;

  modport source (output valid, output event_code, output out_byte,
                  output challenge_last, input ready);
  modport sink   (input valid, input event_code, input out_byte,
                  input challenge_last, output ready);
endinterface

>>> rtl/pop3_response_stream_parser.sv
// ----------------------------------------------------------------------------
// pop3_response_stream_parser
// Parses the server side of a POP3 session one byte per request and reports
// status lines, body bytes, end of message and the APOP challenge.
// ----------------------------------------------------------------------------
//
//  Channel  Role   Payload                                  Per request
//  -------  -----  ---------------------------------------  ------------------
//  req      sink   req_type, data_byte                      one byte or event
//  rsp      source event_code, out_byte, challenge_last     exactly one result
//
//  Timing: a request is registered in the input register on acceptance and its
//  result in the result register as it advances; one request is taken every
//  cycle unless rsp is held. The limit is one state update through p3rsp_step.
//  Reset: rst (synchronous) returns to line start in the greeting phase and
//  empties both registers.
//  Stalls: while rsp is held, the result register keeps its item and the input
//  register can still take one more request before req.ready drops.
//
module pop3_response_stream_parser (
  input logic               clk,
  input logic               rst,
  p3rsp_req_if.sink         req,
  p3rsp_rsp_if.source       rsp
);

  // Input register
  logic               s1_valid;
  logic               s1_req_type;
  logic [7:0]         s1_data_byte;

  // Result register
  logic               s2_valid;
  p3rsp_pkg::result_t s2_res;

  // Parser state
  p3rsp_pkg::state_t  state;
  p3rsp_pkg::state_t  state_next;
  logic               command_seen;
  logic               command_seen_next;
  p3rsp_pkg::result_t step_res;

  logic               s1_advance;
  logic               req_accept;

  // Advance the registered request when the result register is free or drains
  assign s1_advance = s1_valid && (!s2_valid || rsp.ready);
  assign req.ready  = !s1_valid || s1_advance;
  assign req_accept = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_accept) begin
      s1_req_type  <= req.req_type;
      s1_data_byte <= req.data_byte;
    end
  end

  p3rsp_step u_step (
    .state             (state),
    .command_seen      (command_seen),
    .req_type          (s1_req_type),
    .data_byte         (s1_data_byte),
    .state_next        (state_next),
    .command_seen_next (command_seen_next),
    .res               (step_res)
  );

  // Commit the parser state only when the request moves into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= p3rsp_pkg::ST_RESP;
      command_seen <= 1'b0;
    end else if (s1_advance) begin
      state        <= state_next;
      command_seen <= command_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_advance) begin
      s2_valid <= 1'b1;
    end else if (rsp.ready) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      s2_res <= step_res;
    end
  end

  assign rsp.valid          = s2_valid;
  assign rsp.event_code     = s2_res.event_code;
  assign rsp.out_byte       = s2_res.out_byte;
  assign rsp.challenge_last = s2_res.challenge_last;

  // A client command yields an empty result
  a_cmd_empty: assert property (@(posedge clk) disable iff (rst)
    (s1_advance && s1_req_type == p3rsp_pkg::REQ_CLIENT_CMD) |=>
      (s2_valid && s2_res == '0))
    else $error("client command produced a non-empty result");

  // The challenge ends either on '>' or with an empty flag
  a_chal_last: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && s2_res.challenge_last) |->
      ((s2_res.event_code == p3rsp_pkg::EV_CHAL && s2_res.out_byte == p3rsp_pkg::CH_GT) ||
       (s2_res.event_code == p3rsp_pkg::EV_NONE && s2_res.out_byte == 8'd0)))
    else $error("challenge_last on an unexpected result");

  // Once past the greeting, the phase never returns
  a_cmd_sticky: assert property (@(posedge clk) disable iff (rst)
    $past(command_seen) |-> command_seen)
    else $error("command_seen dropped without reset");

  // No byte accompanies an empty event or end of message
  a_zero_byte: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && (s2_res.event_code == p3rsp_pkg::EV_NONE ||
                  s2_res.event_code == p3rsp_pkg::EV_EOM)) |-> (s2_res.out_byte == 8'd0))
    else $error("out_byte set without a byte event");

endmodule

>>> rtl/p3rsp_step.sv
// ----------------------------------------------------------------------------
// p3rsp_step
// Next-state and event logic of the parser for one registered request.
// ----------------------------------------------------------------------------
module p3rsp_step (
  input  p3rsp_pkg::state_t  state,
  input  logic               command_seen,
  input  logic               req_type,
  input  logic [7:0]         data_byte,
  output p3rsp_pkg::state_t  state_next,
  output logic               command_seen_next,
  output p3rsp_pkg::result_t res
);

  logic               is_lf;
  logic               is_o;
  logic               is_k;
  logic               is_e;
  logic               is_r;
  logic               is_blank;
  p3rsp_pkg::state_t  eol_state;
  p3rsp_pkg::state_t  mid_state;

  assign is_lf     = (data_byte == p3rsp_pkg::CH_LF);
  assign is_o      = (data_byte == p3rsp_pkg::CH_O_UC) || (data_byte == p3rsp_pkg::CH_O_LC);
  assign is_k      = (data_byte == p3rsp_pkg::CH_K_UC) || (data_byte == p3rsp_pkg::CH_K_LC);
  assign is_e      = (data_byte == p3rsp_pkg::CH_E_UC) || (data_byte == p3rsp_pkg::CH_E_LC);
  assign is_r      = (data_byte == p3rsp_pkg::CH_R_UC) || (data_byte == p3rsp_pkg::CH_R_LC);
  assign is_blank  = data_byte inside {p3rsp_pkg::CH_SP, p3rsp_pkg::CH_TAB, p3rsp_pkg::CH_VT,
                                       p3rsp_pkg::CH_FF, p3rsp_pkg::CH_CR};
  // A byte that breaks a status match: newline goes straight back to line start
  assign eol_state = is_lf ? p3rsp_pkg::ST_RESP : p3rsp_pkg::ST_EOL;
  assign mid_state = is_lf ? p3rsp_pkg::ST_BSOL : p3rsp_pkg::ST_BMID;

  always_comb begin
    state_next        = state;
    command_seen_next = command_seen;
    res               = '0;
    if (req_type == p3rsp_pkg::REQ_CLIENT_CMD) begin
      command_seen_next = 1'b1;
    end else begin
      case (state)
        p3rsp_pkg::ST_O: begin
          state_next = is_o ? p3rsp_pkg::ST_K : eol_state;
        end
        p3rsp_pkg::ST_K: begin
          if (is_k) begin
            res.event_code = p3rsp_pkg::EV_OK;
            res.out_byte   = data_byte;
            state_next     = p3rsp_pkg::ST_OKSP;
          end else begin
            state_next = eol_state;
          end
        end
        p3rsp_pkg::ST_E: begin
          state_next = is_e ? p3rsp_pkg::ST_R1 : eol_state;
        end
        p3rsp_pkg::ST_R1: begin
          state_next = is_r ? p3rsp_pkg::ST_R2 : eol_state;
        end
        p3rsp_pkg::ST_R2: begin
          if (is_r) begin
            res.event_code = p3rsp_pkg::EV_ERR;
            res.out_byte   = data_byte;
            state_next     = p3rsp_pkg::ST_EOL;
          end else begin
            state_next = eol_state;
          end
        end
        p3rsp_pkg::ST_OKSP: begin
          if (is_blank) begin
            state_next = state;
          end else if (command_seen) begin
            state_next = eol_state;
          end else if (data_byte == p3rsp_pkg::CH_LT) begin
            res.event_code = p3rsp_pkg::EV_CHAL;
            res.out_byte   = data_byte;
            state_next     = p3rsp_pkg::ST_CHAL;
          end else begin
            state_next = is_lf ? p3rsp_pkg::ST_RESP : p3rsp_pkg::ST_LOOK;
          end
        end
        p3rsp_pkg::ST_EOL: begin
          state_next = eol_state;
        end
        p3rsp_pkg::ST_LOOK: begin
          if (data_byte == p3rsp_pkg::CH_LT) begin
            res.event_code = p3rsp_pkg::EV_CHAL;
            res.out_byte   = data_byte;
            state_next     = p3rsp_pkg::ST_CHAL;
          end else if (is_lf) begin
            state_next = p3rsp_pkg::ST_RESP;
          end
        end
        p3rsp_pkg::ST_CHAL: begin
          if (is_lf) begin
            // Capture cut short: flag the end with no byte
            res.challenge_last = 1'b1;
            command_seen_next  = 1'b1;
            state_next         = p3rsp_pkg::ST_RESP;
          end else if (data_byte == p3rsp_pkg::CH_GT) begin
            res.event_code     = p3rsp_pkg::EV_CHAL;
            res.out_byte       = data_byte;
            res.challenge_last = 1'b1;
            command_seen_next  = 1'b1;
            state_next         = p3rsp_pkg::ST_EOL;
          end else begin
            res.event_code = p3rsp_pkg::EV_CHAL;
            res.out_byte   = data_byte;
          end
        end
        p3rsp_pkg::ST_BMID: begin
          res.event_code = p3rsp_pkg::EV_BODY;
          res.out_byte   = data_byte;
          state_next     = mid_state;
        end
        p3rsp_pkg::ST_DOT, p3rsp_pkg::ST_CR: begin
          if (is_lf) begin
            res.event_code = p3rsp_pkg::EV_EOM;
            state_next     = p3rsp_pkg::ST_RESP;
          end else if (state == p3rsp_pkg::ST_DOT && data_byte == p3rsp_pkg::CH_CR) begin
            state_next = p3rsp_pkg::ST_CR;
          end else begin
            res.event_code = p3rsp_pkg::EV_BODY;
            res.out_byte   = data_byte;
            state_next     = mid_state;
          end
        end
        default: begin
          // Line start; body start of line shares the dot and body handling
          if (state != p3rsp_pkg::ST_BSOL && data_byte == p3rsp_pkg::CH_PLUS) begin
            state_next = p3rsp_pkg::ST_O;
          end else if (state != p3rsp_pkg::ST_BSOL && data_byte == p3rsp_pkg::CH_MINUS) begin
            state_next = p3rsp_pkg::ST_E;
          end else if (data_byte == p3rsp_pkg::CH_DOT) begin
            state_next = p3rsp_pkg::ST_DOT;
          end else begin
            res.event_code = p3rsp_pkg::EV_BODY;
            res.out_byte   = data_byte;
            state_next     = mid_state;
          end
        end
      endcase
    end
  end

endmodule

>>> tb/p3rsp_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p3rsp_tb_pkg
// Scoreboard for the POP3 response parser: tracks the line state and the
// greeting phase for every accepted request and checks each event in order.
// ----------------------------------------------------------------------------
package p3rsp_tb_pkg;
  import p3rsp_pkg::*;

  class pop3_event_scoreboard;
    state_t      line_state;
    logic        cmd_seen;
    result_t     expected_events[$];
    int unsigned mismatches;

    function new();
      line_state  = ST_RESP;
      cmd_seen    = 1'b0;
      mismatches  = 0;
    endfunction

    static function logic [7:0] to_upper(logic [7:0] b);
      // 'a' .. 'z' map down by 0x20
      return (b >= 8'h61 && b <= 8'h7A) ? b - 8'h20 : b;
    endfunction

    static function logic is_blank(logic [7:0] b);
      return b inside {CH_SP, CH_TAB, CH_VT, CH_FF, CH_CR};
    endfunction

    static function state_t to_eol(logic [7:0] b);
      return (b == CH_LF) ? ST_RESP : ST_EOL;
    endfunction

    function void body_mid(inout result_t r, input logic [7:0] b);
      r.event_code = EV_BODY;
      r.out_byte   = b;
      line_state   = (b == CH_LF) ? ST_BSOL : ST_BMID;
    endfunction

    function void body_sol(inout result_t r, input logic [7:0] b);
      if (b == CH_DOT) line_state = ST_DOT;
      else body_mid(r, b);
    endfunction

    // Advance the parser by one request and return the event it yields.
    function result_t parse_byte(logic kind, logic [7:0] b);
      result_t r;
      r = '0;
      if (kind == REQ_CLIENT_CMD) begin
        cmd_seen = 1'b1;
        return r;
      end
      case (line_state)
        ST_O:  line_state = (to_upper(b) == CH_O_UC) ? ST_K : to_eol(b);
        ST_K: begin
          if (to_upper(b) == CH_K_UC) begin
            r.event_code = EV_OK;
            r.out_byte   = b;
            line_state   = ST_OKSP;
          end else line_state = to_eol(b);
        end
        ST_E:  line_state = (to_upper(b) == CH_E_UC) ? ST_R1 : to_eol(b);
        ST_R1: line_state = (to_upper(b) == CH_R_UC) ? ST_R2 : to_eol(b);
        ST_R2: begin
          if (to_upper(b) == CH_R_UC) begin
            r.event_code = EV_ERR;
            r.out_byte   = b;
            line_state   = ST_EOL;
          end else line_state = to_eol(b);
        end
        ST_OKSP: begin
          if (!is_blank(b)) begin
            if (cmd_seen) line_state = to_eol(b);
            else if (b == CH_LT) begin
              r.event_code = EV_CHAL;
              r.out_byte   = b;
              line_state   = ST_CHAL;
            end else line_state = (b == CH_LF) ? ST_RESP : ST_LOOK;
          end
        end
        ST_EOL: line_state = to_eol(b);
        ST_LOOK: begin
          if (b == CH_LT) begin
            r.event_code = EV_CHAL;
            r.out_byte   = b;
            line_state   = ST_CHAL;
          end else if (b == CH_LF) line_state = ST_RESP;
        end
        ST_CHAL: begin
          if (b == CH_LF) begin
            r.challenge_last = 1'b1;
            cmd_seen         = 1'b1;
            line_state       = ST_RESP;
          end else if (b == CH_GT) begin
            r.event_code     = EV_CHAL;
            r.out_byte       = b;
            r.challenge_last = 1'b1;
            cmd_seen         = 1'b1;
            line_state       = ST_EOL;
          end else begin
            r.event_code = EV_CHAL;
            r.out_byte   = b;
          end
        end
        ST_BSOL: body_sol(r, b);
        ST_BMID: body_mid(r, b);
        ST_DOT: begin
          if (b == CH_CR) line_state = ST_CR;
          else if (b == CH_LF) begin
            r.event_code = EV_EOM;
            line_state   = ST_RESP;
          end else body_mid(r, b);
        end
        ST_CR: begin
          if (b == CH_LF) begin
            r.event_code = EV_EOM;
            line_state   = ST_RESP;
          end else body_mid(r, b);
        end
        default: begin
          if (b == CH_PLUS) line_state = ST_O;
          else if (b == CH_MINUS) line_state = ST_E;
          else body_sol(r, b);
        end
      endcase
      return r;
    endfunction

    function void note_request(logic kind, logic [7:0] b);
      expected_events.push_back(parse_byte(kind, b));
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_events.size() == 0) begin
        $display("%0t: unexpected event code %0d byte %02h last %0b", $time,
                 got.event_code, got.out_byte, got.challenge_last);
        mismatches++;
        return;
      end
      want = expected_events.pop_front();
      if (got.event_code !== want.event_code) begin
        $display("%0t: event_code expected %0d actual %0d", $time,
                 want.event_code, got.event_code);
        mismatches++;
      end
      if (got.out_byte !== want.out_byte) begin
        $display("%0t: out_byte expected %02h actual %02h", $time,
                 want.out_byte, got.out_byte);
        mismatches++;
      end
      if (got.challenge_last !== want.challenge_last) begin
        $display("%0t: challenge_last expected %0b actual %0b", $time,
                 want.challenge_last, got.challenge_last);
        mismatches++;
      end
    endfunction

    function int unsigned outstanding();
      return expected_events.size();
    endfunction
  endclass

endpackage

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives a POP3 server byte stream and client command events into the
// response parser with random idles and stalls, predicts every event in a
// scoreboard and checks the results in order, field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import p3rsp_pkg::*;
  import p3rsp_tb_pkg::*;

  localparam int unsigned RANDOM_REQUESTS = 1200;
  localparam int unsigned DRAIN_CYCLES    = 8;       // margin for stray results after the drain
  localparam int unsigned CYCLE_LIMIT     = 400000;  // far above the slowest stall pattern

  // One planned request: a server byte or a client command event
  typedef struct packed {
    logic       kind;
    logic [7:0] data;
  } request_t;

  logic clk = 1'b0;
  logic rst;

  p3rsp_req_if req_ch ();
  p3rsp_rsp_if rsp_ch ();

  pop3_response_stream_parser dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #1 clk = ~clk;

  pop3_event_scoreboard tracker;
  request_t             request_plan[$];
  int unsigned          send_quiet;
  int unsigned          recv_quiet;
  int unsigned          recv_stall;
  int unsigned          cycle_count = 0;

  // Idle length for either side: mostly none or short, a few long, and now
  // and then a quiet stretch with no idling at all.
  function automatic int unsigned idle_cycles(inout int unsigned quiet);
    int unsigned r;
    if (quiet != 0) begin
      quiet--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      quiet = $urandom_range(20, 80);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // ---- request plan builders ----------------------------------------------

  function automatic void add_server(logic [7:0] b);
    request_plan.push_back('{kind: REQ_SERVER_BYTE, data: b});
  endfunction

  function automatic void add_command(logic [7:0] b);
    request_plan.push_back('{kind: REQ_CLIENT_CMD, data: b});
  endfunction

  function automatic void add_str(string s);
    for (int i = 0; i < s.len(); i++) add_server(s[i]);
  endfunction

  function automatic logic [7:0] any_case(logic [7:0] uc, logic [7:0] lc);
    return ($urandom_range(0, 1) != 0) ? uc : lc;
  endfunction

  // Random line content: any byte but the newline
  function automatic void add_text(int unsigned n);
    logic [7:0] b;
    repeat (n) begin
      do b = 8'($urandom_range(0, 255)); while (b == CH_LF);
      add_server(b);
    end
  endfunction

  function automatic void add_eol();
    if ($urandom_range(0, 4) != 0) add_server(CH_CR);
    add_server(CH_LF);
  endfunction

  function automatic void add_blanks();
    repeat ($urandom_range(0, 3)) begin
      case ($urandom_range(0, 4))
        0: add_server(CH_SP);
        1: add_server(CH_TAB);
        2: add_server(CH_VT);
        3: add_server(CH_FF);
        default: add_server(CH_CR);
      endcase
    end
  endfunction

  function automatic void add_ok_line();
    add_server(CH_PLUS);
    add_server(any_case(CH_O_UC, CH_O_LC));
    add_server(any_case(CH_K_UC, CH_K_LC));
    add_blanks();
    add_text($urandom_range(0, 10));
    add_eol();
  endfunction

  function automatic void add_err_line();
    add_server(CH_MINUS);
    add_server(any_case(CH_E_UC, CH_E_LC));
    add_server(any_case(CH_R_UC, CH_R_LC));
    add_server(any_case(CH_R_UC, CH_R_LC));
    add_text($urandom_range(0, 10));
    add_eol();
  endfunction

  // Status line that breaks off partway; sometimes right on a newline
  function automatic void add_broken_status();
    case ($urandom_range(0, 3))
      0: add_server(CH_PLUS);
      1: begin
        add_server(CH_PLUS);
        add_server(any_case(CH_O_UC, CH_O_LC));
      end
      2: add_server(CH_MINUS);
      default: begin
        add_server(CH_MINUS);
        add_server(any_case(CH_E_UC, CH_E_LC));
        add_server(any_case(CH_R_UC, CH_R_LC));
      end
    endcase
    if ($urandom_range(0, 3) == 0) add_server(CH_LF);
    else begin
      add_text($urandom_range(1, 6));
      add_eol();
    end
  endfunction

  // Multi-line body with dot stuffing, closed by a lone dot line
  function automatic void add_message();
    repeat ($urandom_range(1, 4)) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          add_server(CH_DOT);
          add_text($urandom_range(1, 8));
        end
        2: begin
          add_server(CH_DOT);
          add_server(CH_CR);
          add_text($urandom_range(1, 8));
        end
        default: add_text($urandom_range(0, 12));
      endcase
      add_eol();
    end
    add_server(CH_DOT);
    add_eol();
  endfunction

  function automatic void add_noise();
    repeat ($urandom_range(1, 6)) add_server(8'($urandom_range(0, 255)));
  endfunction

  function automatic void build_plan();
    int unsigned directed_count;
    int unsigned pick;
    // Directed: mismatch on a bare newline, mixed-case +OK with a tab, text
    // ahead of the challenge, extreme challenge bytes, a challenge cut short
    // by a newline, mixed-case -ERR, a body newline, a dot-CR stuffed line,
    // end of message, and a client command with all data bits set.
    add_server(CH_PLUS);
    add_server(CH_LF);
    add_str("+Ok");
    add_server(CH_TAB);
    add_str("x<");
    add_server(8'h00);
    add_server(8'hFF);
    add_server(CH_LF);
    add_str("-eRr");
    add_server(CH_LF);
    add_server(8'hFF);
    add_server(CH_LF);
    add_server(CH_DOT);
    add_server(CH_CR);
    add_str("x");
    add_server(CH_LF);
    add_server(CH_DOT);
    add_server(CH_CR);
    add_server(CH_LF);
    add_command(8'hFF);
    directed_count = request_plan.size();

    // Random: mostly well-formed lines and messages, some noise and breaks
    while (request_plan.size() < directed_count + RANDOM_REQUESTS) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) add_message();
      else if (pick < 55) add_ok_line();
      else if (pick < 70) add_err_line();
      else if (pick < 80) add_command(8'($urandom_range(0, 255)));
      else if (pick < 90) add_broken_status();
      else add_noise();
    end
  endfunction

  // ---- request driver -----------------------------------------------------

  // Drop valid through the idle gap, then present the request until ready
  // is seen at a rising edge; note it in the scoreboard at that edge.
  task automatic send_request(input request_t item);
    int unsigned gap;
    gap = idle_cycles(send_quiet);
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.req_type  <= item.kind;
    req_ch.data_byte <= item.data;
    do @(posedge clk); while (!req_ch.ready);
    tracker.note_request(item.kind, item.data);
  endtask

  initial begin
    tracker    = new();
    send_quiet = 0;
    rst              <= 1'b1;
    req_ch.valid     <= 1'b0;
    req_ch.req_type  <= REQ_SERVER_BYTE;
    req_ch.data_byte <= 8'h00;
    build_plan();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (request_plan[i]) send_request(request_plan[i]);
    req_ch.valid <= 1'b0;

    // Drain: wait for every expected event, then let stray results show up
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  // ---- result monitor and stall generator ----------------------------------

  // Check on the edge where valid and ready are both high, then pick the
  // next ready value; stalls use the same gap pattern as the sender.
  initial begin
    recv_quiet = 0;
    recv_stall = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid && rsp_ch.ready)
        tracker.check_result('{event_code: rsp_ch.event_code,
                               out_byte: rsp_ch.out_byte,
                               challenge_last: rsp_ch.challenge_last});
      if (recv_stall != 0) begin
        rsp_ch.ready <= 1'b0;
        recv_stall--;
      end else begin
        rsp_ch.ready <= 1'b1;
        recv_stall = idle_cycles(recv_quiet);
      end
    end
  end

  // Watchdog against a hung handshake
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

endmodule

>>> sim.f
rtl/p3rsp_pkg.sv
rtl/p3rsp_req_if.sv
rtl/p3rsp_rsp_if.sv
rtl/p3rsp_step.sv
rtl/pop3_response_stream_parser.sv
tb/p3rsp_tb_pkg.sv
tb/tb_top.sv
